### rtl/sha1_pkg.sv
`default_nettype none

package sha1_pkg;

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K_R00 = 32'h5A827999;
    localparam logic [31:0] K_R20 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R40 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R60 = 32'hCA62C1D6;

    // Initial chaining words, index 0 is H0
    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Source of the data placed into the block by one push step
    typedef enum logic [2:0] {
        SRC_PEND  = 3'd0,
        SRC_PAD80 = 3'd1,
        SRC_ZERO  = 3'd2,
        SRC_LENHI = 3'd3,
        SRC_LENLO = 3'd4
    } src_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_item;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } dig_item_t;

    typedef struct packed {
        logic load;
        logic push_en;
        src_t push_src;
        logic round_en;
        logic fin_en;
        logic restart;
    } cmd_t;

    typedef struct packed {
        logic       pend_empty;
        logic       pend_after_zero;
        logic       wrap;
        logic [5:0] fill_after;
        logic       last;
        logic       round_last;
    } stat_t;

endpackage

`default_nettype wire

### rtl/sha1_out.sv
`default_nettype none

module sha1_out (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire logic [4:0][31:0]    words,
    output logic                     dig_valid,
    input  wire logic                dig_stall,
    output sha1_pkg::dig_item_t      dig_data,
    output logic                     busy
);
    import sha1_pkg::*;

    localparam logic [2:0] LAST_INDEX = 3'd4;

    logic [4:0][31:0] obuf_reg;
    logic [2:0]       idx_reg;
    logic             valid_reg;
    logic             beat;

    assign beat = valid_reg && !dig_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 3'd0;
        end
        else if (beat)
        begin
            idx_reg <= idx_reg + 3'd1;
            if (idx_reg == LAST_INDEX)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Shift the digest down one word per beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obuf_reg <= words;
        end
        else if (beat)
        begin
            for (int i = 0; i < 4; i++)
            begin
                obuf_reg[i] <= obuf_reg[i + 1];
            end
            obuf_reg[4] <= 32'd0;
        end
    end

    assign dig_valid            = valid_reg;
    assign busy                 = valid_reg;
    assign dig_data.digest_word = obuf_reg[0];
    assign dig_data.word_index  = idx_reg;
    assign dig_data.last_word   = (idx_reg == LAST_INDEX);

endmodule

`default_nettype wire

### rtl/sha1_dp.sv
`default_nettype none

module sha1_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sha1_pkg::msg_item_t msg_data,
    input  wire sha1_pkg::cmd_t      cmd,
    output sha1_pkg::stat_t          stat,
    output logic [4:0][31:0]         chain
);
    import sha1_pkg::*;

    localparam logic [6:0] ROUND_LAST = 7'd79;

    logic [4:0][31:0] chain_reg;
    logic [31:0]      blk_reg [16];
    logic [5:0]       fill_reg;
    logic [60:0]      msg_bytes_reg;
    logic [31:0]      pend_reg;
    logic [2:0]       pend_cnt_reg;
    logic             last_reg;
    logic [4:0][31:0] vars_reg;
    logic [6:0]       rcnt_reg;

    logic [2:0]  count_clamp;
    logic [63:0] bit_len;
    logic        word_mode;
    logic [31:0] word_val;
    logic [7:0]  byte_val;
    logic [6:0]  fill_sum;
    logic [3:0]  wi;
    logic [1:0]  lane;
    logic [31:0] byte_placed;
    logic [31:0] write_val;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [31:0] w_mix;
    logic [31:0] w_next;
    logic [31:0] va, vb, vc, vd, ve;

    assign count_clamp = (msg_data.byte_count > 3'd4) ? 3'd4 : msg_data.byte_count;
    assign bit_len     = {msg_bytes_reg, 3'b000};
    assign wi          = fill_reg[5:2];
    assign lane        = fill_reg[1:0];

    always_comb
    begin
        word_mode = 1'b0;
        word_val  = 32'd0;
        byte_val  = 8'd0;
        unique case (cmd.push_src)
            SRC_PEND:
            begin
                word_mode = (lane == 2'd0) && (pend_cnt_reg == 3'd4);
                word_val  = pend_reg;
                byte_val  = pend_reg[31:24];
            end
            SRC_PAD80:
            begin
                byte_val = PAD_BYTE;
            end
            SRC_ZERO:
            begin
                word_mode = (lane == 2'd0);
            end
            SRC_LENHI:
            begin
                word_mode = 1'b1;
                word_val  = bit_len[63:32];
            end
            SRC_LENLO:
            begin
                word_mode = 1'b1;
                word_val  = bit_len[31:0];
            end
            default:
            begin
                word_mode = 1'b0;
            end
        endcase
    end

    assign fill_sum    = {1'b0, fill_reg} + (word_mode ? 7'd4 : 7'd1);
    assign byte_placed = {byte_val, 24'd0} >> {lane, 3'b000};

    // First byte of a word clears it; later bytes merge in
    always_comb
    begin
        if (word_mode)
        begin
            write_val = word_val;
        end
        else if (lane == 2'd0)
        begin
            write_val = byte_placed;
        end
        else
        begin
            write_val = blk_reg[wi] | byte_placed;
        end
    end

    assign va = vars_reg[0];
    assign vb = vars_reg[1];
    assign vc = vars_reg[2];
    assign vd = vars_reg[3];
    assign ve = vars_reg[4];

    always_comb
    begin
        priority if (rcnt_reg < 7'd20)
        begin
            f_val = (vb & vc) | (~vb & vd);
            k_val = K_R00;
        end
        else if (rcnt_reg < 7'd40)
        begin
            f_val = vb ^ vc ^ vd;
            k_val = K_R20;
        end
        else if (rcnt_reg < 7'd60)
        begin
            f_val = (vb & vc) | (vb & vd) | (vc & vd);
            k_val = K_R40;
        end
        else
        begin
            f_val = vb ^ vc ^ vd;
            k_val = K_R60;
        end
    end

    assign t_val  = {va[26:0], va[31:27]} + f_val + ve + k_val + blk_reg[0];
    assign w_mix  = blk_reg[13] ^ blk_reg[8] ^ blk_reg[2] ^ blk_reg[0];
    assign w_next = {w_mix[30:0], w_mix[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg     <= H_INIT;
            fill_reg      <= 6'd0;
            msg_bytes_reg <= 61'd0;
            pend_cnt_reg  <= 3'd0;
            last_reg      <= 1'b0;
            rcnt_reg      <= 7'd0;
        end
        else
        begin
            if (cmd.load)
            begin
                msg_bytes_reg <= msg_bytes_reg + 61'(count_clamp);
                pend_cnt_reg  <= count_clamp;
                last_reg      <= msg_data.last_item;
            end
            if (cmd.push_en)
            begin
                fill_reg <= fill_sum[5:0];
                if (cmd.push_src == SRC_PEND)
                begin
                    pend_cnt_reg <= word_mode ? 3'd0 : (pend_cnt_reg - 3'd1);
                end
                if (fill_sum[6])
                begin
                    rcnt_reg <= 7'd0;
                end
            end
            if (cmd.round_en)
            begin
                rcnt_reg <= rcnt_reg + 7'd1;
            end
            if (cmd.fin_en)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + vars_reg[i];
                end
            end
            if (cmd.restart)
            begin
                chain_reg     <= H_INIT;
                fill_reg      <= 6'd0;
                msg_bytes_reg <= 61'd0;
                last_reg      <= 1'b0;
            end
        end
    end

    // Block buffer doubles as the message schedule window during rounds
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pend_reg <= msg_data.data_word;
        end
        if (cmd.push_en)
        begin
            if ((cmd.push_src == SRC_PEND) && !word_mode)
            begin
                pend_reg <= {pend_reg[23:0], 8'd0};
            end
            blk_reg[wi] <= write_val;
            if (fill_sum[6])
            begin
                vars_reg <= chain_reg;
            end
        end
        if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                blk_reg[i] <= blk_reg[i + 1];
            end
            blk_reg[15] <= w_next;
            vars_reg[4] <= vd;
            vars_reg[3] <= vc;
            vars_reg[2] <= {vb[1:0], vb[31:2]};
            vars_reg[1] <= va;
            vars_reg[0] <= t_val;
        end
    end

    assign stat.pend_empty      = (pend_cnt_reg == 3'd0);
    assign stat.pend_after_zero = word_mode || (pend_cnt_reg == 3'd1);
    assign stat.wrap            = fill_sum[6];
    assign stat.fill_after      = fill_sum[5:0];
    assign stat.last            = last_reg;
    assign stat.round_last      = (rcnt_reg == ROUND_LAST);
    assign chain                = chain_reg;

endmodule

`default_nettype wire

### rtl/sha1_ctrl.sv
`default_nettype none

module sha1_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            msg_valid,
    output logic                 msg_stall,
    input  wire sha1_pkg::stat_t stat,
    input  wire logic            out_busy,
    output sha1_pkg::cmd_t       cmd
);
    import sha1_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PUSH  = 4'd1;
    localparam logic [3:0] S_PAD80 = 4'd2;
    localparam logic [3:0] S_PADZ  = 4'd3;
    localparam logic [3:0] S_LENHI = 4'd4;
    localparam logic [3:0] S_LENLO = 4'd5;
    localparam logic [3:0] S_ROUND = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [5:0] FILL_LEN = 6'd56;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;
    logic [3:0] resume;
    logic [3:0] after_data;
    logic [3:0] after_pad;

    assign after_data = stat.last ? S_PAD80 : S_IDLE;
    assign after_pad  = (stat.fill_after == FILL_LEN) ? S_LENHI : S_PADZ;
    assign msg_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.push_src = SRC_PEND;
        state_next = state_reg;
        ret_next   = ret_reg;
        resume     = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (stat.pend_empty)
                begin
                    state_next = after_data;
                end
                else
                begin
                    cmd.push_en  = 1'b1;
                    cmd.push_src = SRC_PEND;
                    resume       = stat.pend_after_zero ? after_data : S_PUSH;
                end
            end
            S_PAD80:
            begin
                cmd.push_en  = 1'b1;
                cmd.push_src = SRC_PAD80;
                resume       = after_pad;
            end
            S_PADZ:
            begin
                cmd.push_en  = 1'b1;
                cmd.push_src = SRC_ZERO;
                resume       = after_pad;
            end
            S_LENHI:
            begin
                cmd.push_en  = 1'b1;
                cmd.push_src = SRC_LENHI;
                resume       = S_LENLO;
            end
            S_LENLO:
            begin
                cmd.push_en  = 1'b1;
                cmd.push_src = SRC_LENLO;
                resume       = S_DONE;
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (stat.round_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin_en = 1'b1;
                state_next = ret_reg;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.restart = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A full block detours through the rounds, then resumes
        if (cmd.push_en)
        begin
            if (stat.wrap)
            begin
                ret_next   = resume;
                state_next = S_ROUND;
            end
            else
            begin
                state_next = resume;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

`default_nettype wire

### rtl/sha1_hash_engine_core.sv
`default_nettype none

// Channel   Dir  Handshake             Beat payload
// msg       in   msg_valid/msg_stall   data_word, byte_count, last_item
// dig       out  dig_valid/dig_stall   digest_word, word_index, last_word
//
// One message item takes a load step plus one push when a full word lands
// on a word boundary, otherwise one push per byte (up to four). Each full
// 64-byte block then passes through the 80 rounds and a chaining add; the
// single shared round unit sets the pace on a long stream, and msg_stall
// holds new items off meanwhile. The final item adds padding (a byte, zero
// bytes and words, two length words) and one or two blocks, then five digest
// beats. Reset is asynchronous and active low and returns the chaining words
// to the initial values. The digest sits in its own output buffer, so a new
// message is taken while earlier digest beats wait on dig_stall.
module sha1_hash_engine_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                msg_valid,
    output logic                     msg_stall,
    input  wire sha1_pkg::msg_item_t msg_data,
    output logic                     dig_valid,
    input  wire logic                dig_stall,
    output sha1_pkg::dig_item_t      dig_data
);
    import sha1_pkg::*;

    cmd_t             cmd;
    stat_t            stat;
    logic [4:0][31:0] chain;
    logic             out_busy;

    // Sequence loads, pushes, rounds and digest hand-off
    sha1_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .stat      (stat),
        .out_busy  (out_busy),
        .cmd       (cmd)
    );

    // Hold the block, length, chaining words and round variables
    sha1_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .msg_data (msg_data),
        .cmd      (cmd),
        .stat     (stat),
        .chain    (chain)
    );

    // Capture the digest on restart and drain it one word per beat
    sha1_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.restart),
        .words     (chain),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig_data  (dig_data),
        .busy      (out_busy)
    );

endmodule

`default_nettype wire

### sim/sha1_hash_engine_core_tb.sv
`timescale 1ns / 100ps

module sha1_hash_engine_core_tb;

    import sha1_pkg::msg_item_t;
    import sha1_pkg::dig_item_t;

    // Run shape
    localparam int DIR_ROWS    = 21;
    localparam int RAND_ITEMS  = 310;
    localparam int HOLD_AT     = 120;   // random item index that starts the long hold-off
    localparam int HOLD_CYCLES = 600;   // receiver hold-off, long enough to back up the input
    localparam int DRAIN_CYCLES = 300;  // two padded blocks plus the digest beats, with margin
    localparam int IDLE_LIMIT  = 4000;  // cycles with no beat on either channel

    // SHA-1 constants, kept separate from the design's own copies
    localparam logic [31:0] RC_0 = 32'h5A827999;
    localparam logic [31:0] RC_1 = 32'h6ED9EBA1;
    localparam logic [31:0] RC_2 = 32'h8F1BBCDC;
    localparam logic [31:0] RC_3 = 32'hCA62C1D6;
    localparam logic [0:4][31:0] IV_WORDS = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct {
        msg_item_t        item;
        bit               typed;    // digest below is written out by hand
        logic [0:4][31:0] digest;   // index 0 is H0
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      msg_valid;
    logic      msg_stall;
    msg_item_t msg_data;
    logic      dig_valid;
    logic      dig_stall;
    dig_item_t dig_data;

    // Expected digest beats, oldest first
    dig_item_t digest_q [$];

    int  err_count;
    int  quiet_cycles;
    bit  hold_req;
    bit  hold_done;
    bit  quiet_tail;

    // Hashing state of the predictor
    logic [31:0] hash_chain [5];
    logic [31:0] hash_blk [16];
    int unsigned hash_fill;
    logic [60:0] hash_len;

    // Directed rows: two known digests first, then a 62-byte message that walks
    // every byte count (above four counts as four, short words mid-stream just
    // append, dropped low bytes) and needs two padded blocks, then a one-word
    // message of all ones.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{'{32'h0000_0000, 3'd0, 1'b1}, 1'b1,
          {32'hDA39A3EE, 32'h5E6B4B0D, 32'h3255BFEF, 32'h95601890, 32'hAFD80709}},
        '{'{32'h6162_63FF, 3'd3, 1'b1}, 1'b1,
          {32'hA9993E36, 32'h4706816A, 32'hBA3E2571, 32'h7850C26C, 32'h9CD0D89D}},
        '{'{32'hFFFF_FFFF, 3'd4, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0000, 3'd5, 1'b0}, 1'b0, '0},
        '{'{32'hDEAD_BEEF, 3'd6, 1'b0}, 1'b0, '0},
        '{'{32'h0F0F_0F0F, 3'd7, 1'b0}, 1'b0, '0},
        '{'{32'h1234_5678, 3'd1, 1'b0}, 1'b0, '0},
        '{'{32'h9ABC_DEF0, 3'd2, 1'b0}, 1'b0, '0},
        '{'{32'h1357_9BDF, 3'd3, 1'b0}, 1'b0, '0},
        '{'{32'h0123_4567, 3'd4, 1'b0}, 1'b0, '0},
        '{'{32'h89AB_CDEF, 3'd4, 1'b0}, 1'b0, '0},
        '{'{32'hFEDC_BA98, 3'd4, 1'b0}, 1'b0, '0},
        '{'{32'h7654_3210, 3'd4, 1'b0}, 1'b0, '0},
        '{'{32'h8000_0000, 3'd4, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0001, 3'd4, 1'b0}, 1'b0, '0},
        '{'{32'h7FFF_FFFF, 3'd4, 1'b0}, 1'b0, '0},
        '{'{32'hC3D2_E1F0, 3'd4, 1'b0}, 1'b0, '0},
        '{'{32'h5A82_7999, 3'd4, 1'b0}, 1'b0, '0},
        '{'{32'hFFFF_FFFF, 3'd0, 1'b0}, 1'b0, '0},
        '{'{32'hA5A5_A5A5, 3'd4, 1'b1}, 1'b0, '0},
        '{'{32'hFFFF_FFFF, 3'd4, 1'b1}, 1'b0, '0}
    };

    sha1_hash_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_data  (msg_data),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig_data  (dig_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] rol32(logic [31:0] x, int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // Reload the chaining words and clear the length for a new message.
    function automatic void start_message();
        int unsigned i;
        for (i = 0; i < 5; i++)
            hash_chain[i] = IV_WORDS[i];
        hash_fill = 0;
        hash_len  = '0;
    endfunction

    // Run the 80 rounds over the current block and fold into the chain.
    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int unsigned r;
        for (r = 0; r < 16; r++)
            w[r] = hash_blk[r];
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (r = 0; r < 80; r++)
        begin
            if (r >= 16)
                w[r % 16] = rol32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^
                                  w[(r + 2) % 16] ^ w[r % 16], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = RC_0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = RC_1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RC_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RC_3;
            end
            t = rol32(a, 5) + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
    endfunction

    // Place one byte big-endian into the block; compress on a full block.
    function automatic void feed_byte(logic [7:0] v);
        int unsigned wi, sh;
        wi = hash_fill / 4;
        sh = (3 - hash_fill % 4) * 8;
        if (hash_fill % 4 == 0)
            hash_blk[wi] = '0;
        hash_blk[wi] |= {24'h0, v} << sh;
        hash_fill = (hash_fill + 1) % 64;
        if (hash_fill == 0)
            compress_block();
    endfunction

    // Absorb one message beat; on the last beat pad, finish and return 1.
    function automatic bit absorb_item(msg_item_t it, output logic [0:4][31:0] dig);
        int unsigned n, i;
        logic [63:0] bit_len;
        n = (it.byte_count > 3'd4) ? 4 : it.byte_count;
        for (i = 0; i < n; i++)
        begin
            feed_byte(it.data_word[31 - 8 * i -: 8]);
            hash_len = hash_len + 1'b1;
        end
        if (!it.last_item)
            return 1'b0;
        bit_len = {hash_len, 3'b000};
        feed_byte(8'h80);
        while (hash_fill != 56)
            feed_byte(8'h00);
        for (i = 0; i < 8; i++)
            feed_byte(bit_len[63 - 8 * i -: 8]);
        for (i = 0; i < 5; i++)
            dig[i] = hash_chain[i];
        start_message();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        err_count++;
    endtask

    // Compare each digest beat with the oldest expectation.
    always @(posedge clk)
    begin : digest_check
        dig_item_t want;
        if (rst_n && dig_valid && !dig_stall)
        begin
            if (digest_q.size() == 0)
                report_mismatch("unexpected digest beat", dig_data.digest_word, 'x);
            else
            begin
                want = digest_q.pop_front();
                if (dig_data.digest_word !== want.digest_word)
                    report_mismatch("digest_word", dig_data.digest_word, want.digest_word);
                if (dig_data.word_index !== want.word_index)
                    report_mismatch("word_index", dig_data.word_index, want.word_index);
                if (dig_data.last_word !== want.last_word)
                    report_mismatch("last_word", dig_data.last_word, want.last_word);
            end
        end
    end

    // Count cycles with no beat on either side; give up when stuck.
    always @(posedge clk)
    begin
        if ((msg_valid && !msg_stall) || (dig_valid && !dig_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL sha1_hash_engine_core");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Digest receiver: random stall bursts, free stretches, one long hold
    // ------------------------------------------------------------------

    initial
    begin
        int pick;
        dig_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                // Hold off long enough for the engine to back up into msg_stall.
                dig_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (quiet_tail)
                dig_stall <= 1'b0;
            else
            begin
                pick = $urandom_range(99);
                if (pick < 20)
                begin
                    dig_stall <= 1'b1;
                    repeat ($urandom_range(9)) @(negedge clk);
                end
                else if (pick < 24)
                begin
                    dig_stall <= 1'b0;
                    repeat ($urandom_range(59, 20)) @(negedge clk);
                end
                else
                    dig_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Message sender
    // ------------------------------------------------------------------

    // Offer one beat after an optional gap, wait for it to be taken, then
    // queue the digest it finishes, if any.
    task automatic offer_item(msg_item_t it, bit typed, logic [0:4][31:0] typed_dig);
        logic [0:4][31:0] pred;
        dig_item_t        exp_beat;
        int unsigned i, gap;
        if (!quiet_tail && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(10, 1);
            @(negedge clk);
            msg_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        msg_valid <= 1'b1;
        msg_data  <= it;
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        if (absorb_item(it, pred))
        begin
            if (typed)
                pred = typed_dig;
            for (i = 0; i < 5; i++)
            begin
                exp_beat.digest_word = pred[i];
                exp_beat.word_index  = i[2:0];
                exp_beat.last_word   = (i == 4);
                digest_q.insert(digest_q.size(), exp_beat);
            end
        end
    endtask

    initial
    begin
        msg_item_t it;
        int r, sent, len, k, kind;
        err_count    = 0;
        quiet_cycles = 0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        quiet_tail   = 1'b0;
        msg_valid    = 1'b0;
        msg_data     = '0;
        rst_n        = 1'b0;
        start_message();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table.
        for (r = 0; r < DIR_ROWS; r++)
            offer_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].digest);

        // Random messages: mostly short, a few spanning several blocks. Most
        // beats are full words; some are short or over-counted mid-stream.
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 14) : $urandom_range(15);
            for (k = 0; k <= len; k++)
            begin
                it.data_word = $urandom;
                if (k == len)
                begin
                    it.byte_count = 3'($urandom_range(7));
                    it.last_item  = 1'b1;
                end
                else
                begin
                    kind = $urandom_range(19);
                    if (kind == 0)
                        it.byte_count = 3'($urandom_range(3));
                    else if (kind == 1)
                        it.byte_count = 3'($urandom_range(7, 5));
                    else
                        it.byte_count = 3'd4;
                    it.last_item = 1'b0;
                end
                offer_item(it, 1'b0, '0);
                sent++;
                if (sent == HOLD_AT)
                    hold_req = 1'b1;
                if (sent >= RAND_ITEMS * 85 / 100)
                    quiet_tail = 1'b1;
            end
        end

        // Drop valid, drain the outstanding digests, then let the engine settle.
        @(negedge clk);
        msg_valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("PASS sha1_hash_engine_core");
        else
            $display("FAIL sha1_hash_engine_core");
        $finish;
    end

endmodule
